@@ rtl/kdwt_pkg.sv @@
// Shared types and constants for the keyed deadline watchdog table.
package kdwt_pkg;

    localparam int KEY_W  = 16;
    localparam int TIME_W = 48;
    localparam int TMO_W  = 31;
    localparam int TRAW_W = 32;
    localparam int ADV_W  = 16;

    typedef enum logic [1:0] {
        ACT_REGISTER   = 2'd0,
        ACT_UNREGISTER = 2'd1,
        ACT_TICK       = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] deadline;
        logic [TMO_W-1:0]  timeout;
        logic [TIME_W-1:0] cpu_start;
    } slot_t;

endpackage

@@ rtl/kdwt_slot_ram.sv @@
// Single-port-write, registered-read memory holding the watchdog slot entries.
module kdwt_slot_ram #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  kdwt_pkg::slot_t            wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output kdwt_pkg::slot_t            rd_data
);
    import kdwt_pkg::*;

    slot_t mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/keyed_deadline_watchdog_table_unit.sv @@
// Keyed deadline watchdog table: register, unregister and tick against ENTRIES slots.
// The reserved action skips the scan and goes straight to ST_EXEC. A sequential scan reads
// the slot memory one entry per cycle through its registered read port; a stalled result
// holds the unit in ST_EXEC, and a new transaction is taken only in ST_IDLE.
// Reset: all slots become free, CPU total and CPU mode clear at once; no clearing pass.
module keyed_deadline_watchdog_table_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [kdwt_pkg::KEY_W-1:0]    key,
    input  logic signed [kdwt_pkg::TRAW_W-1:0] timeout_ms,
    input  logic [kdwt_pkg::TIME_W-1:0]   now_ms,
    input  logic [kdwt_pkg::ADV_W-1:0]    cpu_advance_ms,
    input  logic                          overslept,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic                          hit,
    output logic [kdwt_pkg::KEY_W-1:0]    hit_key,
    output logic                          hit_by_cpu
);
    import kdwt_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    // Control state
    state_t               state_reg, state_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [TIME_W-1:0]    cpu_total_reg;
    logic                 cpu_mode_reg;
    logic [CNT_W-1:0]     iss_reg;
    logic                 chk_vld_reg;
    logic [IDX_W-1:0]     chk_idx_reg;
    logic                 found_reg, free_found_reg, best_vld_reg;
    logic                 out_valid_reg;

    // Transaction payload
    action_t              act_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [TRAW_W-1:0]    traw_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    dl_reg;
    logic [IDX_W-1:0]     found_idx_reg, free_idx_reg, best_idx_reg;
    logic [TIME_W-1:0]    best_dl_reg, best_cs_reg;
    logic [TMO_W-1:0]     best_to_reg;
    logic [KEY_W-1:0]     best_key_reg;
    logic                 status_reg, hit_reg, hit_by_cpu_reg;
    logic [KEY_W-1:0]     hit_key_reg;

    // Combinational
    action_t              act_in;
    logic                 in_known, acc, out_free, exec_fire;
    logic                 rd_en, scan_last, wr_en;
    logic [IDX_W-1:0]     rd_addr;
    slot_t                rd_data, wr_data;
    logic [TIME_W:0]      dl_sum, cpu_sum;
    logic [TIME_W-1:0]    cpu_used;
    logic                 pos_tmo, fire;
    logic                 res_status, res_hit, res_cpu;
    logic [KEY_W-1:0]     res_key;
    logic                 chk_slot_valid, chk_match, chk_free, chk_better;

    kdwt_slot_ram #(
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode the incoming action
    assign act_in   = action_t'(action);
    assign in_known = (act_in == ACT_REGISTER) || (act_in == ACT_UNREGISTER) ||
                      (act_in == ACT_TICK);
    assign acc      = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Saturating deadline and CPU total sums
    assign dl_sum  = {1'b0, now_ms} + {{(TIME_W + 1 - TMO_W){1'b0}}, timeout_ms[TMO_W-1:0]};
    assign cpu_sum = {1'b0, cpu_total_reg} + {{(TIME_W + 1 - ADV_W){1'b0}}, cpu_advance_ms};

    // Scan addressing: issue one read a cycle, check the returned data in the next cycle
    assign rd_en     = (state_reg == ST_SCAN) && (iss_reg < CNT_W'(ENTRIES));
    assign rd_addr   = iss_reg[IDX_W-1:0];
    assign scan_last = chk_vld_reg && (chk_idx_reg == IDX_W'(ENTRIES - 1));

    // Per-slot checks on the returned entry
    assign chk_slot_valid = valid_reg[chk_idx_reg];
    assign chk_match      = chk_slot_valid && (rd_data.key == key_reg) && !found_reg;
    assign chk_free       = !chk_slot_valid || chk_match;
    assign chk_better     = chk_slot_valid && (!best_vld_reg || (rd_data.deadline < best_dl_reg));

    // Expiry test on the earliest entry
    assign pos_tmo  = !traw_reg[TRAW_W-1] && (traw_reg != '0);
    assign cpu_used = cpu_total_reg - best_cs_reg;
    assign fire     = cpu_mode_reg ? ({{(TIME_W - TMO_W){1'b0}}, best_to_reg} <= cpu_used)
                                   : (best_dl_reg <= now_reg);

    // New slot contents for a register
    assign wr_data.key       = key_reg;
    assign wr_data.deadline  = dl_reg;
    assign wr_data.timeout   = traw_reg[TMO_W-1:0];
    assign wr_data.cpu_start = cpu_total_reg;

    // Next state and handshake
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        exec_fire  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = in_known ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    exec_fire  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result and slot updates at the end of the scan
    always_comb
    begin
        valid_next = valid_reg;
        res_status = 1'b0;
        res_hit    = 1'b0;
        res_key    = '0;
        res_cpu    = 1'b0;
        wr_en      = 1'b0;
        case (act_reg)
            ACT_REGISTER:
            begin
                if (found_reg)
                begin
                    valid_next[found_idx_reg] = 1'b0;
                end
                if (pos_tmo)
                begin
                    if (free_found_reg)
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                        wr_en                    = exec_fire;
                    end
                    else
                    begin
                        res_status = 1'b1;
                    end
                end
            end
            ACT_UNREGISTER:
            begin
                if (found_reg)
                begin
                    valid_next[found_idx_reg] = 1'b0;
                end
            end
            ACT_TICK:
            begin
                if (best_vld_reg && fire)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    res_hit                  = 1'b1;
                    res_key                  = best_key_reg;
                    res_cpu                  = cpu_mode_reg;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            cpu_total_reg  <= '0;
            cpu_mode_reg   <= 1'b0;
            iss_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            best_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                iss_reg        <= '0;
                chk_vld_reg    <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                best_vld_reg   <= 1'b0;
                if (act_in == ACT_TICK)
                begin
                    cpu_total_reg <= cpu_sum[TIME_W] ? {TIME_W{1'b1}} : cpu_sum[TIME_W-1:0];
                    if (overslept)
                    begin
                        cpu_mode_reg <= 1'b1;
                    end
                end
            end
            else if (state_reg == ST_SCAN)
            begin
                iss_reg     <= iss_reg + CNT_W'(rd_en);
                chk_vld_reg <= rd_en;
                chk_idx_reg <= rd_addr;
                if (chk_vld_reg)
                begin
                    if (chk_match)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (chk_free)
                    begin
                        free_found_reg <= 1'b1;
                    end
                    if (chk_better)
                    begin
                        best_vld_reg <= 1'b1;
                    end
                end
            end

            if (exec_fire)
            begin
                valid_reg     <= valid_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the transaction and scan results
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            act_reg  <= act_in;
            key_reg  <= key;
            traw_reg <= timeout_ms;
            now_reg  <= now_ms;
            dl_reg   <= dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
        end
        if ((state_reg == ST_SCAN) && chk_vld_reg)
        begin
            if (chk_match)
            begin
                found_idx_reg <= chk_idx_reg;
            end
            if (chk_free && !free_found_reg)
            begin
                free_idx_reg <= chk_idx_reg;
            end
            if (chk_better)
            begin
                best_idx_reg <= chk_idx_reg;
                best_dl_reg  <= rd_data.deadline;
                best_cs_reg  <= rd_data.cpu_start;
                best_to_reg  <= rd_data.timeout;
                best_key_reg <= rd_data.key;
            end
        end
        if (exec_fire)
        begin
            status_reg     <= res_status;
            hit_reg        <= res_hit;
            hit_key_reg    <= res_key;
            hit_by_cpu_reg <= res_cpu;
        end
    end

    // Drive the result channel
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign hit        = hit_reg;
    assign hit_key    = hit_key_reg;
    assign hit_by_cpu = hit_by_cpu_reg;

endmodule

@@ bench/keyed_deadline_watchdog_table_unit_tb.sv @@
// Self-checking testbench for the keyed deadline watchdog table unit.
`timescale 1ns / 1ps

module keyed_deadline_watchdog_table_unit_tb;

    import kdwt_pkg::*;

    localparam int ENTRIES = 16;
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int unsigned RUN_LIMIT_NS = 10_000_000;

    typedef struct packed {
        logic             status;
        logic             hit;
        logic [KEY_W-1:0] hit_key;
        logic             hit_by_cpu;
    } verdict_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               action;
    logic [KEY_W-1:0]         key;
    logic signed [TRAW_W-1:0] timeout_ms;
    logic [TIME_W-1:0]        now_ms;
    logic [ADV_W-1:0]         cpu_advance_ms;
    logic                     overslept;
    logic                     out_valid;
    logic                     out_ready;
    logic                     status;
    logic                     hit;
    logic [KEY_W-1:0]         hit_key;
    logic                     hit_by_cpu;

    // Predicted watchdog table and CPU-time bookkeeping
    logic                     wd_live [ENTRIES];
    logic [KEY_W-1:0]         wd_key [ENTRIES];
    logic [TIME_W-1:0]        wd_due [ENTRIES];
    logic [TMO_W-1:0]         wd_limit [ENTRIES];
    logic [TIME_W-1:0]        wd_cpu_mark [ENTRIES];
    logic [TIME_W-1:0]        cpu_used_ms;
    logic                     cpu_judged;

    verdict_t                 pending_verdicts [$];
    logic [TIME_W-1:0]        wall_ms;
    bit                       idle_on;
    int                       fail_count;
    int                       items_sent;
    int                       results_checked;
    int                       expiries_seen;
    int                       cpu_expiries_seen;
    int                       drops_seen;

    keyed_deadline_watchdog_table_unit #(
        .ENTRIES        (ENTRIES)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .key            (key),
        .timeout_ms     (timeout_ms),
        .now_ms         (now_ms),
        .cpu_advance_ms (cpu_advance_ms),
        .overslept      (overslept),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .hit            (hit),
        .hit_key        (hit_key),
        .hit_by_cpu     (hit_by_cpu)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one accepted transaction to the predicted table and return its verdict
    function automatic verdict_t next_verdict(input logic [1:0] act,
                                              input logic [KEY_W-1:0] k,
                                              input logic signed [TRAW_W-1:0] tmo,
                                              input logic [TIME_W-1:0] now,
                                              input logic [ADV_W-1:0] adv,
                                              input logic over);
        verdict_t          v;
        int                i;
        int                free_idx;
        int                best;
        bit                removed;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] used;
        logic              fire;
        v = '0;
        free_idx = -1;
        best = -1;
        removed = 1'b0;
        case (act)
            ACT_REGISTER, ACT_UNREGISTER:
            begin
                // drop any entry already holding this key
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (!removed && wd_live[i] && wd_key[i] == k)
                    begin
                        wd_live[i] = 1'b0;
                        removed = 1'b1;
                    end
                end
                if (act == ACT_REGISTER && tmo > 0)
                begin
                    for (i = 0; i < ENTRIES; i++)
                    begin
                        if (free_idx < 0 && !wd_live[i])
                            free_idx = i;
                    end
                    if (free_idx < 0)
                        v.status = 1'b1;
                    else
                    begin
                        sum = {1'b0, now} + {{(TIME_W + 1 - TRAW_W){1'b0}}, tmo};
                        wd_live[free_idx] = 1'b1;
                        wd_key[free_idx] = k;
                        wd_due[free_idx] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                        wd_limit[free_idx] = tmo[TMO_W-1:0];
                        wd_cpu_mark[free_idx] = cpu_used_ms;
                    end
                end
            end
            ACT_TICK:
            begin
                // advance CPU time and latch the oversleep mode before judging
                sum = {1'b0, cpu_used_ms} + {{(TIME_W + 1 - ADV_W){1'b0}}, adv};
                cpu_used_ms = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                if (over)
                    cpu_judged = 1'b1;
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (wd_live[i] && (best < 0 || wd_due[i] < wd_due[best]))
                        best = i;
                end
                if (best >= 0)
                begin
                    used = cpu_used_ms - wd_cpu_mark[best];
                    fire = cpu_judged ? (wd_limit[best] <= used) : (wd_due[best] <= now);
                    if (fire)
                    begin
                        v.hit = 1'b1;
                        v.hit_key = wd_key[best];
                        v.hit_by_cpu = cpu_judged;
                        wd_live[best] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    // Mostly a small pool so that keys collide; now and then any key
    function automatic logic [KEY_W-1:0] pick_key();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(0, 9) == 0)
            return r[KEY_W-1:0];
        return KEY_W'(16'h0A00 + $urandom_range(0, 23));
    endfunction

    function automatic logic signed [TRAW_W-1:0] pick_timeout(input bit cpu_phase);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return $urandom;
        if (sel == 1)
            return 32'sd0 - $urandom_range(0, 5);
        return cpu_phase ? $urandom_range(1, 120000) : $urandom_range(1, 1500);
    endfunction

    // Present one transaction, hold it until accepted, then record its verdict
    task automatic send_op(input logic [1:0] act, input logic [KEY_W-1:0] k,
                           input logic signed [TRAW_W-1:0] tmo, input logic [TIME_W-1:0] now,
                           input logic [ADV_W-1:0] adv, input logic over);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        key            <= k;
        timeout_ms     <= tmo;
        now_ms         <= now;
        cpu_advance_ms <= adv;
        overslept      <= over;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_verdicts.insert(pending_verdicts.size(),
                                next_verdict(act, k, tmo, now, adv, over));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Unregister every key the prediction still holds
    task automatic clear_table();
        int i;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (wd_live[i])
                send_op(ACT_UNREGISTER, wd_key[i], $urandom, rand_time(), ADV_W'($urandom),
                        1'b0);
        end
    endtask

    // Reserved action, unknown key and non-positive timeouts change nothing
    task automatic test_rejected_ops();
        send_op(ACT_RESERVED, 16'hFFFF, 32'sh7FFF_FFFF, TIME_MAX, 16'hFFFF, 1'b1);
        send_op(ACT_UNREGISTER, 16'h1234, 32'sh0000_0064, 48'd0, 16'hFFFF, 1'b1);
        send_op(ACT_REGISTER, 16'h0000, 32'sd0, 48'd10, 16'h0000, 1'b0);
        send_op(ACT_REGISTER, 16'h0005, -32'sd1, 48'd10, 16'h0000, 1'b0);
        send_op(ACT_REGISTER, 16'h0006, 32'sh8000_0000, 48'd10, 16'h0000, 1'b0);
    endtask

    // Fill every slot, see the next register dropped, then replace a key on a full table
    task automatic test_full_table();
        int i;
        send_op(ACT_REGISTER, 16'hFFFF, 32'sd50, 48'd1000, 16'h0000, 1'b0);
        send_op(ACT_REGISTER, 16'h0001, 32'sd50, 48'd1000, 16'h0000, 1'b0);
        for (i = 2; i < ENTRIES; i++)
            send_op(ACT_REGISTER, KEY_W'(16'h0100 + i), 32'sh7FFF_FFFF - i, 48'd1000,
                    16'h0000, 1'b0);
        send_op(ACT_REGISTER, 16'h0200, 32'sd10, 48'd1000, 16'h0000, 1'b0);
        send_op(ACT_REGISTER, 16'h0001, 32'sd50, 48'd1000, 16'h0000, 1'b0);
    endtask

    // Wall-time expiry: not before the deadline, equal deadlines go to the lower slot
    task automatic test_wall_expiry();
        send_op(ACT_TICK, 16'h0000, 32'sd0, 48'd1049, 16'hFFFF, 1'b0);
        send_op(ACT_TICK, 16'h0000, 32'sd0, 48'd1050, 16'h0000, 1'b0);
        send_op(ACT_TICK, 16'h0000, 32'sd0, 48'd1050, 16'h0000, 1'b0);
        send_op(ACT_TICK, 16'h0000, 32'sd0, 48'd1050, 16'h0000, 1'b0);
        clear_table();
    endtask

    // Deadlines past the top of the time range stick at the maximum
    task automatic test_deadline_saturation();
        send_op(ACT_REGISTER, 16'h0007, 32'sh7FFF_FFFF, TIME_MAX - 2, 16'h0000, 1'b0);
        send_op(ACT_REGISTER, 16'h0008, 32'sd1, TIME_MAX - 1, 16'h0000, 1'b0);
        send_op(ACT_TICK, 16'h0000, 32'sd0, TIME_MAX - 1, 16'h0000, 1'b0);
        send_op(ACT_TICK, 16'h0000, 32'sd0, TIME_MAX, 16'h0000, 1'b0);
        send_op(ACT_TICK, 16'h0000, 32'sd0, TIME_MAX, 16'h0000, 1'b0);
    endtask

    // Oversleep latches CPU mode; expiry then follows CPU time used, not wall time
    task automatic test_cpu_mode();
        clear_table();
        send_op(ACT_TICK, 16'h0000, 32'sd0, wall_ms, 16'h0000, 1'b1);
        send_op(ACT_REGISTER, 16'h0009, 32'sd1000, wall_ms, 16'h0000, 1'b0);
        send_op(ACT_TICK, 16'h0000, 32'sd0, TIME_MAX, 16'd999, 1'b0);
        send_op(ACT_TICK, 16'h0000, 32'sd0, 48'd0, 16'd1, 1'b0);
    endtask

    // Mostly well-formed traffic over a small key pool, with some noise
    task automatic test_random_traffic(input bit cpu_phase, input int count);
        int                       n;
        int                       pick;
        logic [1:0]               act;
        logic [KEY_W-1:0]         k;
        logic signed [TRAW_W-1:0] tmo;
        logic [TIME_W-1:0]        now;
        logic [ADV_W-1:0]         adv;
        logic                     over;
        for (n = 0; n < count; n++)
        begin
            // hold back once mid-phase until every verdict is in
            if (n == count / 2)
                wait_results_drained();
            pick = $urandom_range(0, 99);
            k    = pick_key();
            tmo  = $urandom;
            now  = wall_ms;
            adv  = ADV_W'($urandom);
            over = 1'($urandom_range(0, 1));
            if (pick < 40)
            begin
                act = ACT_REGISTER;
                tmo = pick_timeout(cpu_phase);
            end
            else if (pick < 55)
                act = ACT_UNREGISTER;
            else if (pick < 95)
            begin
                act = ACT_TICK;
                wall_ms = wall_ms + TIME_W'($urandom_range(0, 300));
                now = wall_ms;
                if (cpu_phase && $urandom_range(0, 7) != 0)
                    adv = ADV_W'($urandom_range(0, 15000));
                if (!cpu_phase)
                    over = 1'b0;
            end
            else
            begin
                act = 2'($urandom_range(0, 3));
                now = rand_time();
                if (!cpu_phase && act == ACT_TICK)
                    over = 1'b0;
            end
            send_op(act, k, tmo, now, adv, over);
        end
    endtask

    // Downstream ready: random stall bursts while idling is enabled
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    // Compare each result transaction with the oldest predicted verdict
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result with no transaction outstanding: status %0b hit %0b key %h",
                       status, hit, hit_key);
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                results_checked++;
                if (want.hit)
                    expiries_seen++;
                if (want.hit_by_cpu)
                    cpu_expiries_seen++;
                if (want.status)
                    drops_seen++;
                if (status !== want.status)
                begin
                    $error("status: expected %0b, got %0b", want.status, status);
                    fail_count++;
                end
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0b, got %0b", want.hit, hit);
                    fail_count++;
                end
                if (hit_key !== want.hit_key)
                begin
                    $error("hit_key: expected %h, got %h", want.hit_key, hit_key);
                    fail_count++;
                end
                if (hit_by_cpu !== want.hit_by_cpu)
                begin
                    $error("hit_by_cpu: expected %0b, got %0b", want.hit_by_cpu, hit_by_cpu);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        int i;
        int spin;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        action         <= ACT_REGISTER;
        key            <= '0;
        timeout_ms     <= '0;
        now_ms         <= '0;
        cpu_advance_ms <= '0;
        overslept      <= 1'b0;
        for (i = 0; i < ENTRIES; i++)
            wd_live[i] = 1'b0;
        cpu_used_ms = '0;
        cpu_judged = 1'b0;
        wall_ms = 48'd2000;
        idle_on = 1'b1;
        fail_count = 0;
        items_sent = 0;
        results_checked = 0;
        expiries_seen = 0;
        cpu_expiries_seen = 0;
        drops_seen = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_rejected_ops();
        test_full_table();
        test_wall_expiry();
        test_deadline_saturation();
        test_random_traffic(1'b0, 260);
        test_cpu_mode();
        test_random_traffic(1'b1, 120);
        idle_on = 1'b0;
        test_random_traffic(1'b1, 80);

        // Let the last verdicts arrive, then watch for stray results
        in_valid <= 1'b0;
        spin = 0;
        while (pending_verdicts.size() != 0 && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (ENTRIES + 4) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_verdicts.size());
            fail_count++;
        end

        $display("%0d transactions sent, %0d results checked, %0d full-table drops.",
                 items_sent, results_checked, drops_seen);
        $display("%0d watchdog expiries (%0d judged on CPU time), incl. ties and saturation.",
                 expiries_seen, cpu_expiries_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $error("run limit reached with %0d results outstanding", pending_verdicts.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kdwt_pkg.sv
rtl/kdwt_slot_ram.sv
rtl/keyed_deadline_watchdog_table_unit.sv
bench/keyed_deadline_watchdog_table_unit_tb.sv
